### rtl/plt_pkg.sv
// plt_pkg: shared constants, codes and types of the probe loss and latency tracker
// no dependencies; imported by every rtl module of the block

package plt_pkg;

   localparam int DEFAULT_WINDOW_DEPTH = 64;

   localparam int TIME_W     = 64;
   localparam int SEQ_W      = 32;
   localparam int STAT_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int TIMEOUT_W  = 22;
   localparam int REQ_W      = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 22'd10000;

   // request kinds
   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REPLY = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_TIMEOUT = 2'd1;

   typedef struct packed {
      logic drain;   // retire one entry, item stays in the input register
      logic probe;   // finish a tick that sends a probe
      logic reply;   // finish a reply
      logic clear;   // finish a clear
   } win_cmd_type;

   typedef struct packed {
      logic multi_retire;  // more than one entry is due to retire
      logic retired_lost;  // entry retired this cycle was unanswered
      logic reply_hit;     // reply matched an unanswered entry
   } win_stat_type;

   typedef struct packed {
      logic              clear;
      logic              sent_inc;
      logic              lost_inc;
      logic              answer;
      logic [STAT_W-1:0] latency;
   } stats_cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0] sent;
      logic [STAT_W-1:0] lost;
      logic [STAT_W-1:0] answered;
      logic [STAT_W-1:0] sum;
      logic [STAT_W-1:0] max;
      logic [STAT_W-1:0] min;
   } stats_type;

   // all counters zero, minimum all ones
   localparam stats_type STATS_RESET = {{(5*STAT_W){1'b0}}, {STAT_W{1'b1}}};

endpackage

### rtl/plt_window.sv
// plt_window: probe window with answered marks, head and fill count
// retires old entries, appends probes and matches replies; uses plt_pkg

module plt_window #(
   parameter int DEPTH = plt_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [plt_pkg::INTERVAL_W-1:0]       send_interval,
   input  logic [plt_pkg::TIMEOUT_W-1:0]        reply_timeout,
   input  plt_pkg::win_cmd_type                 cmd,
   input  logic [plt_pkg::SEQ_W-1:0]            seq_gap,       // next sequence minus reply seq
   input  logic [plt_pkg::SEQ_W-1:0]            seq_gap_next,  // the same for the next cycle
   output plt_pkg::win_stat_type                stat
);
   import plt_pkg::*;

   localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW + INTERVAL_W > TIMEOUT_W) ? CW + INTERVAL_W : TIMEOUT_W;

   logic [DEPTH-1:0] marks_ff;
   logic [HW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             head_mark_ff, slot_mark_ff;

   logic [MW-1:0] prod, prod_prev, tmo;
   logic          over_now, over_prev;
   logic [HW-1:0] head_inc, slot, pos, h1, mark_addr, slot_nx;
   logic [CW-1:0] off, c1, off_nx;
   logic [HW:0]   slot_sum, pos_sum, slot_nx_sum;
   logic          dist_ok, retire, mark_we, mark_wdata;

   // age test: count * interval against the timeout, and the same one entry less
   assign prod      = MW'(count_ff) * MW'(send_interval);
   assign prod_prev = prod - MW'(send_interval);
   assign tmo       = MW'(reply_timeout);
   assign over_now  = (count_ff != '0) && (prod >= tmo);
   assign over_prev = (count_ff > CW'(1)) && (prod_prev >= tmo);

   assign head_inc = (head_ff == HW'(DEPTH - 1)) ? '0 : head_ff + HW'(1);

   // reply slot: head + count - gap, wrapped once
   assign dist_ok  = (seq_gap != '0) && (seq_gap <= SEQ_W'(count_ff));
   assign off      = count_ff - CW'(seq_gap);
   assign slot_sum = (HW+1)'(head_ff) + (HW+1)'(off);
   assign slot     = (slot_sum >= (HW+1)'(DEPTH)) ? HW'(slot_sum - (HW+1)'(DEPTH))
                                                  : HW'(slot_sum);

   // reply slot of the next cycle, from the next head, count and gap
   assign off_nx      = count_in - CW'(seq_gap_next);
   assign slot_nx_sum = (HW+1)'(head_in) + (HW+1)'(off_nx);
   assign slot_nx     = (slot_nx_sum >= (HW+1)'(DEPTH)) ? HW'(slot_nx_sum - (HW+1)'(DEPTH))
                                                        : HW'(slot_nx_sum);

   // at most one retire per cycle: aged-out head or full window on append
   assign retire = cmd.drain ||
                   (cmd.probe && (over_now || (count_ff == CW'(DEPTH))));
   assign h1     = retire ? head_inc : head_ff;
   assign c1     = retire ? count_ff - CW'(1) : count_ff;

   assign pos_sum = (HW+1)'(h1) + (HW+1)'(c1);
   assign pos     = (pos_sum >= (HW+1)'(DEPTH)) ? HW'(pos_sum - (HW+1)'(DEPTH))
                                                : HW'(pos_sum);

   assign stat.multi_retire = over_now && over_prev;
   assign stat.retired_lost = retire && !head_mark_ff;
   assign stat.reply_hit    = cmd.reply && dist_ok && !slot_mark_ff;

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      mark_we    = 1'b0;
      mark_addr  = pos;
      mark_wdata = 1'b0;
      if (cmd.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (cmd.drain) begin
         head_in  = h1;
         count_in = c1;
      end else if (cmd.probe) begin
         head_in  = h1;
         count_in = c1 + CW'(1);
         mark_we  = 1'b1;
      end else if (stat.reply_hit) begin
         mark_we    = 1'b1;
         mark_addr  = slot;
         mark_wdata = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // mark memory: one write port, head and reply slot read a cycle ahead,
   // a write to the address being read passes straight through
   always_ff @(posedge clock) begin
      if (mark_we) begin
         marks_ff[mark_addr] <= mark_wdata;
      end
      head_mark_ff <= (mark_we && (mark_addr == head_in)) ? mark_wdata : marks_ff[head_in];
      slot_mark_ff <= (mark_we && (mark_addr == slot_nx)) ? mark_wdata : marks_ff[slot_nx];
   end

endmodule

### rtl/plt_stats.sv
// plt_stats: sent, lost and answered counters plus latency sum, max and min
// presents the post-update view with max/min zeroed when nothing answered; uses plt_pkg

module plt_stats (
   input  logic                   clock,
   input  logic                   reset,
   input  plt_pkg::stats_cmd_type cmd,
   output plt_pkg::stats_type     view
);
   import plt_pkg::*;

   stats_type st_ff, st_in;

   always_comb begin
      st_in = st_ff;
      if (cmd.clear) begin
         st_in = STATS_RESET;
      end else begin
         if (cmd.sent_inc) st_in.sent = st_ff.sent + STAT_W'(1);
         if (cmd.lost_inc) st_in.lost = st_ff.lost + STAT_W'(1);
         if (cmd.answer) begin
            st_in.answered = st_ff.answered + STAT_W'(1);
            st_in.sum      = st_ff.sum + cmd.latency;
            if (cmd.latency > st_ff.max) st_in.max = cmd.latency;
            if (cmd.latency < st_ff.min) st_in.min = cmd.latency;
         end
      end
   end

   always_comb begin
      view = st_in;
      if (st_in.answered == '0) begin
         view.max = '0;
         view.min = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATS_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

### rtl/ping_loss_latency_tracker.sv
// ping_loss_latency_tracker: probe sender and reply tracker, top level
// holds config, input and result registers and the probe schedule; uses plt_pkg,
// plt_window and plt_stats
//
// channel  dir  tuser               tdata (lowest bit up)
// req_     in   [1:0] req_type      [63:0] now_time, [95:64] reply_seq,
//                                   [159:96] reply_sent_at
// rsp_     out  [0] probe_valid     [31:0] probe_seq, [95:32] probe_time,
//                                   [127:96] sent_total, [159:128] lost_total,
//                                   [191:160] answered_total, [223:192] latency_sum,
//                                   [255:224] latency_max, [287:256] latency_min
// csr_     in   write enable, 2-bit index, 22-bit data; no read-back
//
// one item per cycle while no drain runs and rsp_ is free, one result per item;
// an accepted item passes the input register, then the result register on rsp_
// a tick that must age out k > 1 window entries holds the input register for
// extra drain steps: the window retires one entry a cycle through its mark read
// reset is synchronous; it clears window, counters, schedule and config to defaults
// the result register lets a new item enter while a result waits on rsp_tready

module ping_loss_latency_tracker #(
   parameter int WINDOW_DEPTH = plt_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // request items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [159:0]                        req_tdata,  // now_time, reply_seq, reply_sent_at
   input  logic [1:0]                          req_tuser,  // req_type
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [287:0]                        rsp_tdata,  // probe_seq .. latency_min
   output logic [0:0]                          rsp_tuser,  // probe_valid
   // configuration writes
   input  logic                                csr_we,
   input  logic [plt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [plt_pkg::TIMEOUT_W-1:0]       csr_wdata
);
   import plt_pkg::*;

   // configuration
   logic [INTERVAL_W-1:0] interval_ff;
   logic [TIMEOUT_W-1:0]  timeout_ff;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [REQ_W-1:0]  type_ff;
   logic [TIME_W-1:0] now_ff;
   logic [SEQ_W-1:0]  rseq_ff, rseq_in;
   logic [TIME_W-1:0] rsent_ff;

   // probe schedule
   logic [SEQ_W-1:0]  next_seq_ff, next_seq_in;
   logic [TIME_W-1:0] next_send_ff, next_send_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [287:0] rsp_data_ff;
   logic         rsp_probe_ff;

   logic          accept, out_free, probing, drain, finish;
   win_cmd_type   win_cmd;
   win_stat_type  win_stat;
   stats_cmd_type st_cmd;
   stats_type     st_view;
   logic [SEQ_W-1:0]  probe_seq;
   logic [TIME_W-1:0] probe_time;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // a due tick; drain steps age out surplus entries before the final step
   assign probing = in_valid_ff && (type_ff == REQ_TICK) && (next_send_ff <= now_ff);
   assign drain   = probing && win_stat.multi_retire;
   assign finish  = in_valid_ff && out_free && !drain;

   assign req_tready = !in_valid_ff || finish;

   assign win_cmd.drain = drain;
   assign win_cmd.probe = finish && probing;
   assign win_cmd.reply = finish && (type_ff == REQ_REPLY);
   assign win_cmd.clear = finish && (type_ff == REQ_CLEAR);

   // reply sequence held in the input register next cycle
   assign rseq_in = accept ? req_tdata[95:64] : rseq_ff;

   // the window reads its marks a cycle ahead, so it also gets the next gap
   plt_window #(
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .send_interval (interval_ff),
      .reply_timeout (timeout_ff),
      .cmd           (win_cmd),
      .seq_gap       (next_seq_ff - rseq_ff),
      .seq_gap_next  (next_seq_in - rseq_in),
      .stat          (win_stat)
   );

   // latency wraps at 32 bits, only the low halves matter
   assign st_cmd.clear    = win_cmd.clear;
   assign st_cmd.sent_inc = win_cmd.probe;
   assign st_cmd.lost_inc = win_stat.retired_lost;
   assign st_cmd.answer   = win_stat.reply_hit;
   assign st_cmd.latency  = now_ff[STAT_W-1:0] - rsent_ff[STAT_W-1:0];

   plt_stats u_stats (
      .clock (clock),
      .reset (reset),
      .cmd   (st_cmd),
      .view  (st_view)
   );

   // schedule: clear keeps the sequence number but restarts the send time
   always_comb begin
      next_seq_in  = next_seq_ff;
      next_send_in = next_send_ff;
      if (win_cmd.clear) begin
         next_send_in = '0;
      end else if (win_cmd.probe) begin
         next_seq_in  = next_seq_ff + SEQ_W'(1);
         next_send_in = now_ff + TIME_W'(interval_ff);
      end
   end

   assign probe_seq  = win_cmd.probe ? next_seq_ff : '0;
   assign probe_time = win_cmd.probe ? now_ff : '0;

   assign in_valid_in  = accept ? 1'b1 : (finish ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = finish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= INTERVAL_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         next_seq_ff  <= '0;
         next_send_ff <= '0;
      end else begin
         if (csr_we && (csr_index == CSR_SEND_INTERVAL)) begin
            interval_ff <= csr_wdata[INTERVAL_W-1:0];
         end
         if (csr_we && (csr_index == CSR_REPLY_TIMEOUT)) begin
            timeout_ff <= csr_wdata;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         next_seq_ff  <= next_seq_in;
         next_send_ff <= next_send_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_tuser;
         now_ff   <= req_tdata[63:0];
         rseq_ff  <= req_tdata[95:64];
         rsent_ff <= req_tdata[159:96];
      end
      if (finish) begin
         rsp_probe_ff <= win_cmd.probe;
         rsp_data_ff  <= {st_view.min, st_view.max, st_view.sum, st_view.answered,
                          st_view.lost, st_view.sent, probe_time, probe_seq};
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_probe_ff;

   // a drain step never lets a new item in
   a_drain_stalls: assert property (@(posedge clock) disable iff (reset)
      drain |-> !req_tready)
      else $error("input accepted during window drain");

   // each sent probe advances the sequence by exactly one
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      win_cmd.probe |=> (next_seq_ff == $past(next_seq_ff) + SEQ_W'(1)))
      else $error("sequence did not advance after probe");

   // a waiting result leaves only when taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_tready))
      else $error("result dropped without handshake");

   // once anything is answered the minimum never exceeds the maximum
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[191:160] != '0)) |->
         (rsp_data_ff[287:256] <= rsp_data_ff[255:224]))
      else $error("latency min above max");

endmodule

### bench/tb.sv
// tb: self-checking bench for the probe loss and latency tracker
// drives request items with random idling, predicts each result and checks it field by field
// depends on plt_pkg and the rtl top level ping_loss_latency_tracker only

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import plt_pkg::*;

   localparam int DEPTH         = DEFAULT_WINDOW_DEPTH;
   localparam int HEAD_W        = $clog2(DEPTH);
   localparam int SETTLE_CYCLES = 8;     // drains finish before the result
   localparam int REPORT_LIMIT  = 10;
   localparam int TX_BUSY_PCT   = 23;
   localparam int RX_BUSY_PCT   = 47;

   // request code the block must ignore
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct {
      logic              probe_valid;
      logic [SEQ_W-1:0]  probe_seq;
      logic [TIME_W-1:0] probe_time;
      stats_type         stats;
   } tracker_result_type;

   // dut connections, all inputs known from time zero
   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [159:0]  req_tdata  = '0;   // now_time, reply_seq, reply_sent_at
   logic [1:0]    req_tuser  = '0;   // req_type
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [287:0]  rsp_tdata;         // probe_seq, probe_time, sent, lost, answered, sum, max, min
   logic [0:0]    rsp_tuser;         // probe_valid
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIMEOUT_W-1:0] csr_wdata = '0;

   ping_loss_latency_tracker #(
      .WINDOW_DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #(1_000_000);
      $display("tb: errors");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // tracker shadow: config, window and statistics as the block should hold them
   // ---------------------------------------------------------------------------
   logic [INTERVAL_W-1:0] send_gap;
   logic [TIMEOUT_W-1:0]  age_limit;
   logic                  answered_bit [DEPTH];
   logic [HEAD_W-1:0]     win_head;
   logic [HEAD_W:0]       win_fill;
   logic [SEQ_W-1:0]      seq_next;
   logic [TIME_W-1:0]     send_due;
   stats_type             tally;      // min holds all ones while nothing is answered

   // send time of each recent probe, so replies can echo it
   logic [TIME_W-1:0]     probe_time_log [256];

   tracker_result_type pending_stats [$];

   int tx_idle_pct = TX_BUSY_PCT;
   int rx_idle_pct = RX_BUSY_PCT;
   int mismatches  = 0;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic clear_window();
      for (int i = 0; i < DEPTH; i++) answered_bit[i] = 1'b0;
      win_head       = '0;
      win_fill       = '0;
      send_due       = '0;
      tally.sent     = '0;
      tally.lost     = '0;
      tally.answered = '0;
      tally.sum      = '0;
      tally.max      = '0;
      tally.min      = '1;
   endtask

   task automatic retire_oldest_entry();
      if (win_fill == 0) return;
      if (!answered_bit[win_head]) tally.lost++;
      win_head++;
      win_fill--;
   endtask

   // update the shadow for one accepted item and queue the result it must produce
   task automatic track_item(input logic [REQ_W-1:0] kind, input logic [TIME_W-1:0] now_t,
                             input logic [SEQ_W-1:0] rseq, input logic [TIME_W-1:0] rsent);
      tracker_result_type res;
      logic [SEQ_W-1:0]  seq_dist;
      logic [HEAD_W-1:0] slot;
      logic [STAT_W-1:0] lat;
      res.probe_valid = 1'b0;
      res.probe_seq   = '0;
      res.probe_time  = '0;
      case (kind)
         REQ_TICK: begin
            if (send_due <= now_t) begin
               // age out while the window spans the reply timeout
               while (win_fill != 0 && 64'(win_fill) * 64'(send_gap) >= 64'(age_limit))
                  retire_oldest_entry();
               // full window drops its oldest entry
               if (win_fill >= DEPTH) retire_oldest_entry();
               res.probe_valid = 1'b1;
               res.probe_seq   = seq_next;
               res.probe_time  = now_t;
               probe_time_log[seq_next[7:0]] = now_t;
               slot = win_head + HEAD_W'(win_fill);
               answered_bit[slot] = 1'b0;
               seq_next++;
               win_fill++;
               tally.sent++;
               send_due = now_t + 64'(send_gap);   // wraps at 64 bits
            end
         end
         REQ_REPLY: begin
            // stale, future and duplicate replies change nothing
            seq_dist = seq_next - rseq;
            if (seq_dist != 0 && seq_dist <= 32'(win_fill)) begin
               slot = win_head + HEAD_W'(32'(win_fill) - seq_dist);
               if (!answered_bit[slot]) begin
                  lat = now_t[31:0] - rsent[31:0];
                  answered_bit[slot] = 1'b1;
                  tally.answered++;
                  tally.sum = tally.sum + lat;
                  if (lat > tally.max) tally.max = lat;
                  if (lat < tally.min) tally.min = lat;
               end
            end
         end
         REQ_CLEAR: clear_window();   // sequence counter survives
         default: ;
      endcase
      res.stats = tally;
      if (tally.answered == 0) begin
         res.stats.max = '0;
         res.stats.min = '0;
      end
      pending_stats.push_back(res);
   endtask

   // ---------------------------------------------------------------------------
   // driving side
   // ---------------------------------------------------------------------------

   // one item onto req_, with random idle cycles ahead of it
   task automatic send_item(input logic [REQ_W-1:0] kind, input logic [TIME_W-1:0] now_t,
                            input logic [SEQ_W-1:0] rseq, input logic [TIME_W-1:0] rsent);
      while ($urandom_range(99) < tx_idle_pct) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {rsent, rseq, now_t};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      track_item(kind, now_t, rseq, rsent);
   endtask

   // drop valid, then wait for every queued result and a few quiet cycles
   task automatic drain_results();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIMEOUT_W-1:0] val);
      drain_results();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_we <= 1'b0;
      if (idx == CSR_SEND_INTERVAL) send_gap = val[INTERVAL_W-1:0];
      else if (idx == CSR_REPLY_TIMEOUT) age_limit = val;
   endtask

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // ---------------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------------
   task automatic check_field(input string field, input logic [63:0] want_v,
                              input logic [63:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("tb: mismatch in %s, expected %0h, got %0h", field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      tracker_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("tb: result item with nothing pending, tdata %0h", rsp_tdata);
         end else begin
            want = pending_stats[0];
            pending_stats.delete(0);
            check_field("probe_valid",    64'(want.probe_valid),    64'(rsp_tuser[0]));
            check_field("probe_seq",      64'(want.probe_seq),      64'(rsp_tdata[31:0]));
            check_field("probe_time",     want.probe_time,          rsp_tdata[95:32]);
            check_field("sent_total",     64'(want.stats.sent),     64'(rsp_tdata[127:96]));
            check_field("lost_total",     64'(want.stats.lost),     64'(rsp_tdata[159:128]));
            check_field("answered_total", 64'(want.stats.answered), 64'(rsp_tdata[191:160]));
            check_field("latency_sum",    64'(want.stats.sum),      64'(rsp_tdata[223:192]));
            check_field("latency_max",    64'(want.stats.max),      64'(rsp_tdata[255:224]));
            check_field("latency_min",    64'(want.stats.min),      64'(rsp_tdata[287:256]));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   // mostly well-formed traffic: ticks near the send time, replies to window entries,
   // some noise with random fields, rare clears
   task automatic random_mix(input int n_items, input int clear_per_mil);
      logic [REQ_W-1:0]  kind;
      logic [TIME_W-1:0] now_t;
      logic [TIME_W-1:0] rsent;
      logic [SEQ_W-1:0]  rseq;
      logic [SEQ_W-1:0]  seq_dist;
      int                pick;
      for (int i = 0; i < n_items; i++) begin
         pick  = $urandom_range(999);
         now_t = rand64();
         rsent = rand64();
         rseq  = $urandom;
         kind  = REQ_TICK;
         if (pick < clear_per_mil) begin
            kind = REQ_CLEAR;
         end else if (pick < 450) begin
            // tick just short of or past the send time
            if ($urandom_range(4) == 0) now_t = send_due - 64'($urandom_range(8, 1));
            else now_t = send_due + 64'($urandom_range(32'(send_gap) * 2 + 2, 0));
         end else if (pick < 850) begin
            // reply inside the window, now and then a stale or future one
            kind     = REQ_REPLY;
            seq_dist = $urandom_range(32'(win_fill) + 2, 0);
            rseq     = seq_next - seq_dist;
            if ($urandom_range(9) != 0) rsent = probe_time_log[rseq[7:0]];
            now_t = rsent + 64'($urandom_range(4000, 0));
         end else begin
            // noise: random fields on any code but clear
            case ($urandom_range(2))
               0:       kind = REQ_TICK;
               1:       kind = REQ_REPLY;
               default: kind = REQ_UNUSED;
            endcase
         end
         send_item(kind, now_t, rseq, rsent);
      end
   endtask

   // field extremes, every request code, the named corner cases
   task automatic test_directed();
      send_item(REQ_TICK,   64'd0,    32'd0, 64'd0);            // first probe at time zero
      send_item(REQ_TICK,   64'd999,  32'd0, 64'd0);            // not yet due
      send_item(REQ_REPLY,  64'd100,  32'd0, 64'd0);            // answer to the first probe
      send_item(REQ_REPLY,  64'd150,  32'd0, 64'd0);            // duplicate
      send_item(REQ_REPLY,  64'd150,  32'd1, 64'd0);            // future, distance zero
      send_item(REQ_REPLY,  64'd0,    32'hFFFF_FFFF, TIME_MAX); // stale
      send_item(REQ_UNUSED, TIME_MAX, 32'hFFFF_FFFF, TIME_MAX); // unused code
      send_item(REQ_TICK,   64'd1000, 32'd0, 64'd0);
      send_item(REQ_REPLY,  64'd1000, 32'd1, TIME_MAX);         // latency wraps below zero
      send_item(REQ_TICK,   64'd2000, 32'd0, 64'd0);
      send_item(REQ_REPLY,  TIME_MAX, 32'd2, 64'd0);            // largest latency
      send_item(REQ_TICK,   TIME_MAX - 64'd10, 32'd0, 64'd0);   // send time wraps
      send_item(REQ_TICK,   64'd989,  32'd0, 64'd0);            // due after the wrap
      send_item(REQ_REPLY,  64'd0,    32'd3, 64'd0);            // zero latency
      send_item(REQ_CLEAR,  64'd0,    32'd0, 64'd0);
      send_item(REQ_REPLY,  64'd5,    32'd4, 64'd0);            // window empty after clear
      send_item(REQ_UNUSED, 64'd0,    32'd0, 64'd0);
      send_item(REQ_TICK,   64'd0,    32'd0, 64'd0);            // clear restarts schedule
      send_item(REQ_TICK,   TIME_MAX, 32'd0, 64'd0);
      send_item(REQ_CLEAR,  TIME_MAX, 32'hFFFF_FFFF, TIME_MAX);
   endtask

   task automatic test_default_window();
      random_mix(240, 5);
   endtask

   // long timeout, short interval: the window fills and saturates
   task automatic test_full_window();
      write_reg(CSR_SEND_INTERVAL, TIMEOUT_W'(1));
      write_reg(CSR_REPLY_TIMEOUT, '1);
      random_mix(240, 2);
   endtask

   // widest interval, shortest nonzero timeout: the full window left over ages out in one tick
   task automatic test_long_interval();
      write_reg(CSR_SEND_INTERVAL, TIMEOUT_W'(16'hFFFF));
      write_reg(CSR_REPLY_TIMEOUT, TIMEOUT_W'(1));
      random_mix(240, 5);
   endtask

   // zero interval sends on every tick at or after the last probe time, zero timeout empties the window first
   task automatic test_zero_registers();
      write_reg(CSR_SEND_INTERVAL, '0);
      write_reg(CSR_REPLY_TIMEOUT, '0);
      random_mix(200, 5);
   endtask

   task automatic test_random_settings();
      for (int r = 0; r < 4; r++) begin
         write_reg(CSR_SEND_INTERVAL, TIMEOUT_W'($urandom_range(300, 1)));
         write_reg(CSR_REPLY_TIMEOUT, TIMEOUT_W'($urandom_range(20000, 1)));
         random_mix(60, 5);
      end
   endtask

   task automatic test_back_to_back();
      write_reg(CSR_SEND_INTERVAL, TIMEOUT_W'(INTERVAL_RESET));
      write_reg(CSR_REPLY_TIMEOUT, TIMEOUT_RESET);
      random_mix(200, 5);
   endtask

   initial begin
      // shadow starts from the reset state
      send_gap  = INTERVAL_RESET;
      age_limit = TIMEOUT_RESET;
      seq_next  = '0;
      for (int i = 0; i < 256; i++) probe_time_log[i] = '0;
      clear_window();

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // sender idles 23 percent, receiver stalls 47 percent
      test_directed();
      test_default_window();
      test_full_window();

      // the other way round
      drain_results();
      tx_idle_pct = RX_BUSY_PCT;
      rx_idle_pct = TX_BUSY_PCT;
      test_long_interval();
      test_zero_registers();

      // no idling
      drain_results();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_settings();
      test_back_to_back();

      drain_results();
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
